### rtl/ehbu_pkg.sv
// Shared types, constants and hex helpers for the escaped hex byte unescaper.
`default_nettype none

package ehbu_pkg;

    // Reset values of the two configuration registers.
    localparam logic [7:0] START_CHAR_RESET = 8'h23;
    localparam logic [7:0] END_CHAR_RESET   = 8'h2C;

    // Configuration register indexes.
    localparam logic CFG_START_CHAR = 1'b0;
    localparam logic CFG_END_CHAR   = 1'b1;

    // Width of the reported byte count.
    localparam int unsigned SHOWN_COUNT_W = 16;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_AFTER_START,
        MODE_DIGITS,
        MODE_DROP
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_BUSY,
        STATUS_DONE,
        STATUS_FAIL
    } t_status;

    // Parser state that lives between characters (the byte count is kept apart).
    typedef struct packed {
        t_mode       mode;
        logic [1:0]  digit_count;
        logic [7:0]  first_digit;
        logic [7:0]  second_digit;
    } t_parse_state;

    // What one character produces.
    typedef struct packed {
        logic        res_valid;
        logic        byte_valid;
        logic [7:0]  out_byte;
        t_status     status;
        logic        clear_total;
    } t_parse_out;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // Letters map to their low nibble plus nine; callers check is_hex.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] low;
        low = c[3:0];
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            return low;
        end
        return low + 4'd9;
    endfunction

endpackage

`default_nettype wire

### rtl/escaped_hex_byte_unescaper.sv
// Path: input register, then parser, then result register.
// Throughput: one character per cycle unless m_tready stalls; the input register
//   and the result register let a new character in while a finished word waits.
// Reset (synchronous, i_rst_n low): both registers empty, parser in pass-through
//   mode with a zero byte count, start and end characters back to '#' and ','.
`default_nettype none

module escaped_hex_byte_unescaper #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    // Character stream in.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_char
    input  wire logic        s_tlast,   // end_of_message
    // Result stream out.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] bytes_written
    output logic [2:0]       m_tuser    // [0] byte_valid, [2:1] msg_status
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam int unsigned SW = ehbu_pkg::SHOWN_COUNT_W;

    logic [7:0] r_start_char;
    logic [7:0] r_end_char;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eom;

    ehbu_pkg::t_parse_state r_state;
    ehbu_pkg::t_parse_state n_state;
    ehbu_pkg::t_parse_out   parse_out;
    logic [COUNT_WIDTH-1:0] r_total;
    logic [COUNT_WIDTH-1:0] n_total;
    logic [COUNT_WIDTH-1:0] inc_total;
    logic [COUNT_WIDTH-1:0] shown_src;
    logic [COUNT_WIDTH+SW-1:0] shown_ext;
    logic [SW-1:0]          shown;

    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_bvalid;
    ehbu_pkg::t_status      r_out_status;
    logic [SW-1:0]          r_out_count;

    logic out_free;
    logic advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= ehbu_pkg::START_CHAR_RESET;
            r_end_char   <= ehbu_pkg::END_CHAR_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == ehbu_pkg::CFG_START_CHAR) begin
                r_start_char <= i_cfg_wdata;
            end
            if (i_cfg_addr == ehbu_pkg::CFG_END_CHAR) begin
                r_end_char <= i_cfg_wdata;
            end
        end
    end

    // Handshake: the held character moves on when the result slot is free.
    assign out_free = !r_out_valid || m_tready;
    assign advance  = r_in_valid && out_free;
    assign s_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_char <= s_tdata;
            r_in_eom  <= s_tlast;
        end
    end

    ehbu_parse u_parse (
        .i_state      (r_state),
        .i_char       (r_in_char),
        .i_eom        (r_in_eom),
        .i_start_char (r_start_char),
        .i_end_char   (r_end_char),
        .o_state      (n_state),
        .o_out        (parse_out)
    );

    // Saturating byte count and its 16-bit report.
    assign inc_total = (r_total == COUNT_MAX) ? r_total : r_total + COUNT_WIDTH'(1);
    assign shown_src = parse_out.byte_valid ? inc_total : r_total;
    assign shown_ext = {{SW{1'b0}}, shown_src};
    assign shown     = (shown_ext[COUNT_WIDTH+SW-1:SW] != '0) ? {SW{1'b1}}
                                                               : shown_ext[SW-1:0];
    assign n_total   = parse_out.clear_total ? '0 : shown_src;

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode         <= ehbu_pkg::MODE_NORMAL;
            r_state.digit_count  <= 2'd0;
            r_state.first_digit  <= 8'h00;
            r_state.second_digit <= 8'h00;
            r_total              <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_total <= n_total;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && parse_out.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && parse_out.res_valid) begin
            r_out_byte   <= parse_out.out_byte;
            r_out_bvalid <= parse_out.byte_valid;
            r_out_status <= parse_out.status;
            r_out_count  <= shown;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out_count, r_out_byte};
    assign m_tuser  = {r_out_status, r_out_bvalid};

    // A failed word never carries a byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ehbu_pkg::STATUS_FAIL)) |-> !r_out_bvalid)
        else $error("failed word carries a byte");

    // A word in mid-message is only ever a byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ehbu_pkg::STATUS_BUSY)) |-> r_out_bvalid)
        else $error("mid-message word without a byte");

    // Dropping after a failure keeps a zero count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == ehbu_pkg::MODE_DROP) |-> (r_total == '0))
        else $error("count not cleared while dropping");

    // Pass-through mode holds no gathered digits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == ehbu_pkg::MODE_NORMAL) |-> (r_state.digit_count == 2'd0))
        else $error("digits left over in pass-through mode");

endmodule

`default_nettype wire

### rtl/ehbu_parse.sv
// Next-state and result logic of the unescaper for one character.
`default_nettype none

module ehbu_parse (
    input  wire ehbu_pkg::t_parse_state i_state,
    input  wire logic [7:0]             i_char,
    input  wire logic                   i_eom,
    input  wire logic [7:0]             i_start_char,
    input  wire logic [7:0]             i_end_char,
    output ehbu_pkg::t_parse_state      o_state,
    output ehbu_pkg::t_parse_out        o_out
);

    logic       emit;
    logic       fail;
    logic       close_esc;
    logic [7:0] emit_val;
    logic [7:0] close_hi;
    logic [7:0] close_lo;
    logic       is_start;
    logic       is_end;
    logic       close_ok;
    logic [7:0] close_byte;
    ehbu_pkg::t_parse_state kept;

    assign is_start = (i_char == i_start_char);
    assign is_end   = (i_char == i_end_char);

    // Decide what the character does in the current mode.
    always_comb begin
        emit      = 1'b0;
        fail      = 1'b0;
        close_esc = 1'b0;
        emit_val  = i_char;
        close_hi  = 8'h30;
        close_lo  = i_state.first_digit;
        kept      = i_state;
        case (i_state.mode)
            ehbu_pkg::MODE_NORMAL: begin
                if (is_start) begin
                    if (i_eom) begin
                        fail = 1'b1;
                    end else begin
                        kept.mode = ehbu_pkg::MODE_AFTER_START;
                    end
                end else begin
                    emit = 1'b1;
                end
            end
            ehbu_pkg::MODE_AFTER_START: begin
                if (is_start) begin
                    emit = 1'b1;
                end else if (is_end) begin
                    fail = 1'b1;
                end else begin
                    kept.first_digit = i_char;
                    kept.digit_count = 2'd1;
                    kept.mode        = ehbu_pkg::MODE_DIGITS;
                    if (i_eom) begin
                        // A lone digit is the low nibble.
                        close_esc = 1'b1;
                        close_hi  = 8'h30;
                        close_lo  = i_char;
                    end
                end
            end
            ehbu_pkg::MODE_DIGITS: begin
                if (is_end) begin
                    close_esc = 1'b1;
                    if (i_state.digit_count == 2'd1) begin
                        close_hi = 8'h30;
                        close_lo = i_state.first_digit;
                    end else begin
                        close_hi = i_state.first_digit;
                        close_lo = i_state.second_digit;
                    end
                end else if (i_state.digit_count >= 2'd2) begin
                    fail = 1'b1;
                end else begin
                    kept.second_digit = i_char;
                    kept.digit_count  = 2'd2;
                    if (i_eom) begin
                        close_esc = 1'b1;
                        close_hi  = i_state.first_digit;
                        close_lo  = i_char;
                    end
                end
            end
            default: begin
                // Dropping the rest of a failed message.
                if (i_eom) begin
                    kept.mode = ehbu_pkg::MODE_NORMAL;
                end
            end
        endcase
    end

    // Closing an escape checks both digits and merges the nibbles.
    assign close_ok   = ehbu_pkg::is_hex(close_hi) && ehbu_pkg::is_hex(close_lo);
    assign close_byte = {ehbu_pkg::nibble_of(close_hi), ehbu_pkg::nibble_of(close_lo)};

    // Assemble the result word and the next state.
    always_comb begin
        o_state            = kept;
        o_out.res_valid    = 1'b0;
        o_out.byte_valid   = 1'b0;
        o_out.out_byte     = 8'h00;
        o_out.status       = ehbu_pkg::STATUS_BUSY;
        o_out.clear_total  = 1'b0;
        if (fail || (close_esc && !close_ok)) begin
            o_out.res_valid    = 1'b1;
            o_out.status       = ehbu_pkg::STATUS_FAIL;
            o_out.clear_total  = 1'b1;
            o_state.mode         = i_eom ? ehbu_pkg::MODE_NORMAL : ehbu_pkg::MODE_DROP;
            o_state.digit_count  = 2'd0;
            o_state.first_digit  = 8'h00;
            o_state.second_digit = 8'h00;
        end else if (emit || close_esc) begin
            o_out.res_valid    = 1'b1;
            o_out.byte_valid   = 1'b1;
            o_out.out_byte     = close_esc ? close_byte : emit_val;
            o_out.status       = i_eom ? ehbu_pkg::STATUS_DONE : ehbu_pkg::STATUS_BUSY;
            o_out.clear_total  = i_eom;
            o_state.mode         = ehbu_pkg::MODE_NORMAL;
            o_state.digit_count  = 2'd0;
            o_state.first_digit  = 8'h00;
            o_state.second_digit = 8'h00;
        end else if (i_eom) begin
            o_out.clear_total = 1'b1;
        end
    end

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the escaped hex byte unescaper.
`timescale 1ns / 1ps

module testbench;

    // One result word as the block reports it.
    typedef struct packed {
        logic [7:0]        byte_out;
        logic              has_byte;
        ehbu_pkg::t_status status;
        logic [15:0]       count;
    } t_word;

    localparam int unsigned RANDOM_ITEMS = 1575;
    localparam int unsigned IDLE_PERCENT = 17;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = ehbu_pkg::CFG_START_CHAR;
    logic [7:0]  i_cfg_wdata = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] in_char
    logic        s_tlast = 1'b0;    // end_of_message
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [7:0] out_byte, [23:8] bytes_written
    logic [2:0]  m_tuser;           // [0] byte_valid, [2:1] msg_status

    // Decoder copy: configuration and per-message parsing state.
    logic [7:0]      open_char = ehbu_pkg::START_CHAR_RESET;
    logic [7:0]      close_char = ehbu_pkg::END_CHAR_RESET;
    ehbu_pkg::t_mode dec_mode = ehbu_pkg::MODE_NORMAL;
    logic [1:0]      dec_ndigits = 2'd0;
    logic [7:0]      dec_digit_hi = 8'h00;
    logic [7:0]      dec_digit_lo = 8'h00;
    logic [15:0]     dec_total = 16'd0;

    t_word       expected_words[$];
    logic [7:0]  message_chars[$];
    int unsigned fault_count = 0;
    int unsigned items_sent = 0;
    logic        steady_tx = 1'b0;
    logic        steady_rx = 1'b0;

    escaped_hex_byte_unescaper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Counts a failure and reports the first few in detail.
    task automatic report_fault(input string text);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: %s", $realtime, text);
        end
    endtask

    // Returns {is hex, nibble value} for one character.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, c[3:0]};
        end
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    function void clear_message();
        dec_mode = ehbu_pkg::MODE_NORMAL;
        dec_ndigits = 2'd0;
        dec_digit_hi = 8'h00;
        dec_digit_lo = 8'h00;
        dec_total = 16'd0;
    endfunction

    function void queue_word(input logic [7:0] b, input logic has_byte,
                             input ehbu_pkg::t_status st);
        t_word w;
        w.byte_out = has_byte ? b : 8'h00;
        w.has_byte = has_byte;
        w.status = st;
        w.count = dec_total;
        expected_words.push_back(w);
    endfunction

    // Emits one byte; the count saturates and the message closes on the last character.
    function void emit_byte(input logic [7:0] b, input logic last);
        if (dec_total != 16'hFFFF) begin
            dec_total = dec_total + 16'd1;
        end
        dec_mode = ehbu_pkg::MODE_NORMAL;
        dec_ndigits = 2'd0;
        dec_digit_hi = 8'h00;
        dec_digit_lo = 8'h00;
        queue_word(b, 1'b1, last ? ehbu_pkg::STATUS_DONE : ehbu_pkg::STATUS_BUSY);
        if (last) begin
            clear_message();
        end
    endfunction

    // Reports the failure, then drops the rest of the message unless it has ended.
    function void fail_message(input logic last);
        queue_word(8'h00, 1'b0, ehbu_pkg::STATUS_FAIL);
        clear_message();
        if (!last) begin
            dec_mode = ehbu_pkg::MODE_DROP;
        end
    endfunction

    // Turns the gathered digits into a byte; a lone digit is the low nibble.
    function void close_escape(input logic last);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [4:0] nh;
        logic [4:0] nl;
        hi = (dec_ndigits == 2'd1) ? 8'h30 : dec_digit_hi;
        lo = (dec_ndigits == 2'd1) ? dec_digit_hi : dec_digit_lo;
        nh = hex_nibble(hi);
        nl = hex_nibble(lo);
        if (!nh[4] || !nl[4]) begin
            fail_message(last);
        end else begin
            emit_byte({nh[3:0], nl[3:0]}, last);
        end
    endfunction

    // Works out what one accepted character produces.
    function void decode_char(input logic [7:0] c, input logic last);
        case (dec_mode)
            ehbu_pkg::MODE_NORMAL: begin
                if (c == open_char) begin
                    if (last) begin
                        fail_message(last);
                    end else begin
                        dec_mode = ehbu_pkg::MODE_AFTER_START;
                    end
                end else begin
                    emit_byte(c, last);
                end
            end
            ehbu_pkg::MODE_AFTER_START: begin
                if (c == open_char) begin
                    emit_byte(c, last);
                end else if (c == close_char) begin
                    fail_message(last);
                end else begin
                    dec_digit_hi = c;
                    dec_ndigits = 2'd1;
                    dec_mode = ehbu_pkg::MODE_DIGITS;
                    if (last) begin
                        close_escape(last);
                    end
                end
            end
            ehbu_pkg::MODE_DIGITS: begin
                if (c == close_char) begin
                    close_escape(last);
                end else if (dec_ndigits >= 2'd2) begin
                    fail_message(last);
                end else begin
                    dec_digit_lo = c;
                    dec_ndigits = 2'd2;
                    if (last) begin
                        close_escape(last);
                    end
                end
            end
            default: begin
                if (last) begin
                    clear_message();
                end
            end
        endcase
    endfunction

    // Result side: random back-pressure, except during steady stretches.
    always @(posedge i_clk) begin
        m_tready <= steady_rx || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Compares every accepted result word with the oldest expected one.
    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.byte_out = m_tdata[7:0];
            got.has_byte = m_tuser[0];
            got.status = ehbu_pkg::t_status'(m_tuser[2:1]);
            got.count = m_tdata[23:8];
            if (expected_words.size() == 0) begin
                report_fault($sformatf(
                    "unexpected word: byte %02h valid %0d status %0d count %0d",
                    got.byte_out, got.has_byte, got.status, got.count));
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    report_fault($sformatf(
                        "mismatch: byte %02h/%02h valid %0d/%0d status %0d/%0d count %0d/%0d",
                        want.byte_out, got.byte_out, want.has_byte, got.has_byte,
                        want.status, got.status, want.count, got.count));
                end
            end
        end
    end

    // Sends one character, with random idle cycles ahead of it.
    task automatic send_char(input logic [7:0] c, input logic last);
        while (!steady_tx && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        decode_char(c, last);
        items_sent++;
    endtask

    // Sends the buffered message, marking its final character.
    task automatic send_message();
        for (int i = 0; i < message_chars.size(); i++) begin
            send_char(message_chars[i], i == message_chars.size() - 1);
        end
        message_chars.delete();
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            message_chars.push_back(text[i]);
        end
        send_message();
    endtask

    // Holds off the sender until every expected word is in and the pipeline is empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic addr, input logic [7:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == ehbu_pkg::CFG_START_CHAR) begin
            open_char = value;
        end else begin
            close_char = value;
        end
    endtask

    task automatic set_markers(input logic [7:0] open_value, input logic [7:0] close_value);
        write_register(ehbu_pkg::CFG_START_CHAR, open_value);
        write_register(ehbu_pkg::CFG_END_CHAR, close_value);
    endtask

    function automatic logic [7:0] pick_hex_char();
        string hex_set;
        hex_set = "0123456789abcdefABCDEF";
        return hex_set[$urandom_range(0, 21)];
    endfunction

    // Builds a random message: mostly plain text and well-formed escapes, some broken ones.
    task automatic build_message();
        int unsigned segments;
        int unsigned pick;
        int unsigned ndig;
        logic        tail;
        segments = $urandom_range(1, 10);
        for (int k = 0; k < segments; k++) begin
            pick = $urandom_range(0, 99);
            tail = (k == segments - 1);
            if (pick < 50) begin
                message_chars.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 82) begin
                ndig = $urandom_range(1, 2);
                message_chars.push_back(open_char);
                repeat (ndig) message_chars.push_back(pick_hex_char());
                if (!tail || $urandom_range(0, 1)) begin
                    message_chars.push_back(close_char);
                end
            end else if (pick < 88) begin
                message_chars.push_back(open_char);
                message_chars.push_back(open_char);
            end else begin
                message_chars.push_back(open_char);
                case ($urandom_range(0, 3))
                    0: message_chars.push_back(close_char);
                    1: begin
                        repeat (3) message_chars.push_back(pick_hex_char());
                        message_chars.push_back(close_char);
                    end
                    2: begin
                        message_chars.push_back(8'($urandom_range(0, 255)));
                        message_chars.push_back(pick_hex_char());
                        message_chars.push_back(close_char);
                    end
                    default: ;
                endcase
            end
        end
    endtask

    // Plain bytes, literal start, short and long escapes, and every failure kind.
    task automatic test_basic_escapes();
        message_chars.push_back(8'h00);
        message_chars.push_back(8'hFF);
        send_message();
        send_text("z##");
        send_text("#4,#7f,#Ab");
        send_text("#,q");
        send_text("#123");
        send_text("#g1,");
        send_text("k#");
        send_text("#5");
    endtask

    // With one character as both markers, it is literal after a start and closes digits.
    task automatic test_equal_markers();
        set_markers(8'h7C, 8'h7C);
        send_text("||x");
        send_text("|5|");
        send_text("|");
    endtask

    // Random messages over several marker settings, the extremes among them.
    task automatic test_random_messages();
        logic [7:0] opens[7];
        logic [7:0] closes[7];
        int unsigned phase_target;
        opens  = '{8'h23, 8'h00, 8'hFF, 8'h7C, 8'h00, 8'h00, 8'h23};
        closes = '{8'h2C, 8'hFF, 8'h00, 8'h7C, 8'h00, 8'h00, 8'h2C};
        opens[4] = 8'($urandom_range(0, 255));
        closes[4] = 8'($urandom_range(0, 255));
        opens[5] = 8'($urandom_range(0, 255));
        closes[5] = 8'($urandom_range(0, 255));
        for (int p = 0; p < 7; p++) begin
            set_markers(opens[p], closes[p]);
            steady_tx = (p == 3);
            steady_rx = (p == 3);
            phase_target = items_sent + RANDOM_ITEMS / 7;
            while (items_sent < phase_target) begin
                build_message();
                send_message();
            end
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;
    endtask

    initial begin
        int unsigned wait_cycles;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_escapes();
        test_equal_markers();
        test_random_messages();

        // Let the last words come out before the final check.
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (expected_words.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            report_fault($sformatf("%0d expected words never arrived", expected_words.size()));
        end
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### escaped_hex_byte_unescaper.f
rtl/ehbu_pkg.sv
rtl/ehbu_parse.sv
rtl/escaped_hex_byte_unescaper.sv
test/testbench.sv
